// File: hdl/mcpf_pkg.sv
// Package for the multi-channel pipe table: sizes, codes and request/result types.
`default_nettype none

package mcpf_pkg;

    // Table geometry.
    localparam int PIPE_COUNT = 4;
    localparam int RING_DEPTH = 4096;
    localparam int MAX_READ   = 64;

    // Field widths.
    localparam int HANDLE_W = 12;
    localparam int BASE_W   = 11;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 7;

    // Derived widths.
    localparam int SLOT_W = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int MEM_DEPTH = PIPE_COUNT * RING_DEPTH;
    localparam int ADDR_W = $clog2(MEM_DEPTH);

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(1000);

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_READ   = 2'd1,
        MODE_WRITE  = 2'd2,
        MODE_CLOSE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERROR = 2'd1,
        ST_BLOCK = 2'd2,
        ST_EOS   = 2'd3
    } status_t;

    typedef struct packed {
        mode_t               mode;
        logic [HANDLE_W-1:0] handle;
        logic [BYTE_W-1:0]   write_byte;
        logic [COUNT_W-1:0]  read_count;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   read_byte;
        logic                last;
        logic [HANDLE_W-1:0] new_read_handle;
        logic [HANDLE_W-1:0] new_write_handle;
        logic                handle_in_use;
        logic                handle_is_read_end;
    } res_t;

endpackage

`default_nettype wire

// File: hdl/multi_channel_pipe_fifo.sv
// Top level of the multi-channel pipe table: request stage, slot state and result register.
`default_nettype none

// A table of byte pipes, each a ring in one shared RAM with its own pointers, fill count
// and open flags. Create, write, close and any read that ends at once (error, would block,
// end of stream) give one result each, and a new request is taken in every cycle while
// results flow. A read that returns n bytes gives one result per cycle unless stalled and
// holds the request stage until its last byte, as every byte goes through the single read
// port of the ring RAM. The result register lets the next request be taken in while a
// result waits. Ring contents need no clearing after reset; slot state is ready at once.

module multi_channel_pipe_fifo (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire mcpf_pkg::req_t                req_data,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output mcpf_pkg::res_t                     res_data,
    input  wire logic                          cfg_we,
    input  wire logic [mcpf_pkg::BASE_W-1:0]   cfg_data
);

    localparam int PC  = mcpf_pkg::PIPE_COUNT;
    localparam int HW  = mcpf_pkg::HANDLE_W;
    localparam int SW  = mcpf_pkg::SLOT_W;
    localparam int PW  = mcpf_pkg::PTR_W;
    localparam int FW  = mcpf_pkg::FILL_W;
    localparam int AW  = mcpf_pkg::ADDR_W;
    localparam int CW  = mcpf_pkg::COUNT_W;

    // Configuration.
    logic [mcpf_pkg::BASE_W-1:0] base_reg;

    // Request stage.
    logic            e_valid_reg;
    mcpf_pkg::req_t  e_req_reg;
    logic [CW-1:0]   e_rem_reg;
    logic [CW-1:0]   rem_load;

    // Slot state.
    logic [PW-1:0] rp_reg [PC];
    logic [PW-1:0] wp_reg [PC];
    logic [FW-1:0] fill_reg [PC];
    logic          ropen_reg [PC];
    logic          wopen_reg [PC];
    logic          used_reg [PC];

    // Result register.
    logic            r_valid_reg;
    mcpf_pkg::res_t  r_reg;
    logic            r_byte_reg;

    // Decode of the current request.
    logic [HW-1:0]   off;
    logic [HW-2:0]   off_half;
    logic            mapped;
    logic [SW-1:0]   slot;
    logic            even;
    logic            in_use;
    logic            is_read;
    logic            found;
    logic [SW-1:0]   free_idx;
    logic [HW-1:0]   new_rh;
    logic [FW-1:0]   cur_fill;
    logic [PW-1:0]   cur_rp;
    logic [PW-1:0]   cur_wp;
    logic [PW-1:0]   rp_inc;
    logic [PW-1:0]   wp_inc;
    mcpf_pkg::res_t  res;
    logic            do_create;
    logic            do_rd_byte;
    logic            do_write;
    logic            do_close;
    logic            adv;
    logic            accept;

    // Ring RAM.
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [mcpf_pkg::BYTE_W-1:0] ram_q;

    function automatic logic [HW-1:0] req_handle_off(
        input logic [HW-1:0]               h,
        input logic [mcpf_pkg::BASE_W-1:0] b
    );
        req_handle_off = h - HW'(b);
    endfunction

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= mcpf_pkg::BASE_RESET;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_data;
        end
    end

    // Handle mapping and free-slot search.
    always_comb
    begin
        off      = req_handle_off(e_req_reg.handle, base_reg);
        off_half = off[HW-1:1];
        mapped   = (e_req_reg.handle >= HW'(base_reg)) && (off_half < (HW-1)'(PC));
        slot     = off_half[SW-1:0];
        even     = !off[0];
        in_use   = mapped && used_reg[slot];
        is_read  = in_use && even;

        found    = 1'b0;
        free_idx = '0;
        for (int i = PC - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                found    = 1'b1;
                free_idx = SW'(i);
            end
        end
        new_rh = HW'(base_reg) + HW'({free_idx, 1'b0});

        cur_fill = fill_reg[slot];
        cur_rp   = rp_reg[slot];
        cur_wp   = wp_reg[slot];
        rp_inc   = (cur_rp == PW'(mcpf_pkg::RING_DEPTH - 1)) ? '0 : cur_rp + PW'(1);
        wp_inc   = (cur_wp == PW'(mcpf_pkg::RING_DEPTH - 1)) ? '0 : cur_wp + PW'(1);
    end

    // Result and state action of the request in the stage.
    always_comb
    begin
        res                    = '0;
        res.status             = mcpf_pkg::ST_ERROR;
        res.last               = 1'b1;
        res.handle_in_use      = in_use;
        res.handle_is_read_end = is_read;
        do_create  = 1'b0;
        do_rd_byte = 1'b0;
        do_write   = 1'b0;
        do_close   = 1'b0;

        unique case (e_req_reg.mode)
            mcpf_pkg::MODE_CREATE:
            begin
                if (found)
                begin
                    res.status           = mcpf_pkg::ST_OK;
                    res.new_read_handle  = new_rh;
                    res.new_write_handle = new_rh + HW'(1);
                    do_create            = 1'b1;
                end
            end
            mcpf_pkg::MODE_READ:
            begin
                if (is_read)
                begin
                    if (cur_fill == '0)
                    begin
                        res.status = wopen_reg[slot] ? mcpf_pkg::ST_BLOCK : mcpf_pkg::ST_EOS;
                    end
                    else
                    begin
                        res.status = mcpf_pkg::ST_OK;
                        res.last   = (e_rem_reg == CW'(1)) || (cur_fill == FW'(1));
                        do_rd_byte = 1'b1;
                    end
                end
            end
            mcpf_pkg::MODE_WRITE:
            begin
                if (in_use && !even && ropen_reg[slot])
                begin
                    if (cur_fill >= FW'(mcpf_pkg::RING_DEPTH))
                    begin
                        res.status = mcpf_pkg::ST_BLOCK;
                    end
                    else
                    begin
                        res.status = mcpf_pkg::ST_OK;
                        do_write   = 1'b1;
                    end
                end
            end
            mcpf_pkg::MODE_CLOSE:
            begin
                if (in_use)
                begin
                    res.status = mcpf_pkg::ST_OK;
                    do_close   = 1'b1;
                end
            end
            default:
            begin
                res.status = mcpf_pkg::ST_ERROR;
            end
        endcase
    end

    // Handshake: one result leaves the stage per advance; the request ends on its last one.
    assign adv       = e_valid_reg && (!r_valid_reg || !res_stall);
    assign req_stall = e_valid_reg && !(adv && res.last);
    assign accept    = req_valid && !req_stall;

    // Read count clamped to one through the largest burst.
    always_comb
    begin
        if (req_data.read_count == '0)
        begin
            rem_load = CW'(1);
        end
        else if (req_data.read_count > CW'(mcpf_pkg::MAX_READ))
        begin
            rem_load = CW'(mcpf_pkg::MAX_READ);
        end
        else
        begin
            rem_load = req_data.read_count;
        end
    end

    // Request stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            e_valid_reg <= 1'b1;
        end
        else if (adv && res.last)
        begin
            e_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_req_reg <= req_data;
            e_rem_reg <= rem_load;
        end
        else if (adv && do_rd_byte)
        begin
            e_rem_reg <= e_rem_reg - CW'(1);
        end
    end

    // Slot state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PC; i++)
            begin
                rp_reg[i]    <= '0;
                wp_reg[i]    <= '0;
                fill_reg[i]  <= '0;
                ropen_reg[i] <= 1'b0;
                wopen_reg[i] <= 1'b0;
                used_reg[i]  <= 1'b0;
            end
        end
        else if (adv)
        begin
            if (do_create)
            begin
                rp_reg[free_idx]    <= '0;
                wp_reg[free_idx]    <= '0;
                fill_reg[free_idx]  <= '0;
                ropen_reg[free_idx] <= 1'b1;
                wopen_reg[free_idx] <= 1'b1;
                used_reg[free_idx]  <= 1'b1;
            end
            if (do_rd_byte)
            begin
                rp_reg[slot]   <= rp_inc;
                fill_reg[slot] <= cur_fill - FW'(1);
            end
            if (do_write)
            begin
                wp_reg[slot]   <= wp_inc;
                fill_reg[slot] <= cur_fill + FW'(1);
            end
            if (do_close)
            begin
                if (even)
                begin
                    ropen_reg[slot] <= 1'b0;
                    if (!wopen_reg[slot])
                    begin
                        used_reg[slot] <= 1'b0;
                    end
                end
                else
                begin
                    wopen_reg[slot] <= 1'b0;
                    if (!ropen_reg[slot])
                    begin
                        used_reg[slot] <= 1'b0;
                    end
                end
            end
        end
    end

    // Ring addresses: slot base plus pointer.
    assign ram_waddr = AW'(slot) * AW'(mcpf_pkg::RING_DEPTH) + AW'(cur_wp);
    assign ram_raddr = AW'(slot) * AW'(mcpf_pkg::RING_DEPTH) + AW'(cur_rp);

    mcpf_ring_ram #(
        .DEPTH (mcpf_pkg::MEM_DEPTH),
        .WIDTH (mcpf_pkg::BYTE_W),
        .ADDR_W(AW)
    ) u_ring (
        .clk  (clk),
        .we   (adv && do_write),
        .waddr(ram_waddr),
        .wdata(e_req_reg.write_byte),
        .re   (adv && do_rd_byte),
        .raddr(ram_raddr),
        .q    (ram_q)
    );

    // Result register; the byte itself sits in the RAM's read register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            r_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg      <= res;
            r_byte_reg <= do_rd_byte;
        end
    end

    // Result port.
    always_comb
    begin
        res_data = r_reg;
        if (r_byte_reg)
        begin
            res_data.read_byte = ram_q;
        end
    end

    assign res_valid = r_valid_reg;

endmodule

`default_nettype wire

// File: hdl/mcpf_ring_ram.sv
// Simple dual-port RAM holding the ring bytes of all pipes, with registered read.
`default_nettype none

module mcpf_ring_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  q
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            q <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/mcpf_checker.sv
// Port-level checker for the multi-channel pipe table, bound to the top level.
`default_nettype none

module mcpf_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           res_valid,
    input wire logic           res_stall,
    input wire mcpf_pkg::res_t res_data
);

    // A stalled result stays in place unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed or vanished");

    // Any result other than ok ends its request.
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.status != mcpf_pkg::ST_OK) |-> res_data.last)
        else $error("failing result not marked last");

    // A byte is only ever carried by an ok result.
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.read_byte != '0) |-> res_data.status == mcpf_pkg::ST_OK)
        else $error("byte on a non-ok result");

    // Handles from a create come as a pair, write end one above read end.
    a_handle_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.new_write_handle != '0) |->
            (res_data.new_write_handle ==
             mcpf_pkg::HANDLE_W'(res_data.new_read_handle + 1)) && res_data.last)
        else $error("create handles do not pair up");

    // A read end is always an in-use handle.
    a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.handle_is_read_end |-> res_data.handle_in_use)
        else $error("read end reported on a handle not in use");

endmodule

bind multi_channel_pipe_fifo mcpf_checker u_mcpf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
);

`default_nettype wire

// File: dv/multi_channel_pipe_fifo_tb.sv
// Self-checking testbench for the multi-channel pipe table, with its own prediction of every result.
`timescale 1ns / 100ps

module multi_channel_pipe_fifo_tb;

    import mcpf_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 32;
    localparam int REPORT_MAX   = 10;

    // Block ports.
    logic              clk;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    req_t              req_data  = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    res_t              res_data;
    logic              cfg_we    = 1'b0;
    logic [BASE_W-1:0] cfg_data  = BASE_RESET;

    // Predicted copy of the pipe table.
    logic [BYTE_W-1:0] ring_copy [MEM_DEPTH];
    bit [PTR_W-1:0]    pipe_rd_ptr [PIPE_COUNT];
    bit [PTR_W-1:0]    pipe_wr_ptr [PIPE_COUNT];
    bit [FILL_W-1:0]   pipe_fill   [PIPE_COUNT];
    bit                reader_live [PIPE_COUNT];
    bit                writer_live [PIPE_COUNT];
    bit                slot_busy   [PIPE_COUNT];
    logic [BASE_W-1:0] base_now = BASE_RESET;

    // Results still owed by the block, oldest first.
    res_t pending_results [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  idle_en        = 1'b1;
    bit  hold_go        = 1'b0;
    bit  res_hold       = 1'b0;

    multi_channel_pipe_fifo uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run-away guard.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic string res_text(input res_t r);
        return $sformatf("status=%s byte=%02h last=%0b rh=%0d wh=%0d in_use=%0b read_end=%0b",
                         r.status.name(), r.read_byte, r.last, r.new_read_handle,
                         r.new_write_handle, r.handle_in_use, r.handle_is_read_end);
    endfunction

    function automatic void owe_result(input status_t st, input logic [BYTE_W-1:0] b,
                                       input bit lst, input logic [HANDLE_W-1:0] rh,
                                       input logic [HANDLE_W-1:0] wh, input bit in_use,
                                       input bit is_rd);
        res_t r;
        r.status             = st;
        r.read_byte          = b;
        r.last               = lst;
        r.new_read_handle    = rh;
        r.new_write_handle   = wh;
        r.handle_in_use      = in_use;
        r.handle_is_read_end = is_rd;
        pending_results.push_back(r);
    endfunction

    // Works out the results of one accepted request and advances the predicted table.
    function automatic void predict_pipe_results(input req_t r);
        logic [HANDLE_W-1:0] off;
        logic [HANDLE_W-1:0] rh;
        int slot;
        int fresh;
        int n;
        int i;
        int addr;
        bit in_use;
        bit even;
        bit is_rd;

        slot   = 0;
        in_use = 1'b0;
        even   = 1'b0;
        if (r.handle >= {1'b0, base_now})
        begin
            off = r.handle - {1'b0, base_now};
            if (int'(off) / 2 < PIPE_COUNT)
            begin
                slot   = int'(off) / 2;
                even   = ~off[0];
                in_use = slot_busy[slot];
            end
        end
        is_rd = in_use && even;

        case (r.mode)
            MODE_CREATE:
            begin
                fresh = -1;
                for (i = 0; i < PIPE_COUNT; i++)
                    if (fresh < 0 && !slot_busy[i])
                        fresh = i;
                if (fresh < 0)
                    owe_result(ST_ERROR, '0, 1'b1, '0, '0, in_use, is_rd);
                else
                begin
                    pipe_rd_ptr[fresh] = '0;
                    pipe_wr_ptr[fresh] = '0;
                    pipe_fill[fresh]   = '0;
                    reader_live[fresh] = 1'b1;
                    writer_live[fresh] = 1'b1;
                    slot_busy[fresh]   = 1'b1;
                    rh = HANDLE_W'(base_now) + HANDLE_W'(2 * fresh);
                    owe_result(ST_OK, '0, 1'b1, rh, rh + 1'b1, in_use, is_rd);
                end
            end
            MODE_READ:
            begin
                if (!is_rd)
                    owe_result(ST_ERROR, '0, 1'b1, '0, '0, in_use, is_rd);
                else if (pipe_fill[slot] == 0)
                    owe_result(writer_live[slot] ? ST_BLOCK : ST_EOS, '0, 1'b1, '0, '0,
                               in_use, is_rd);
                else
                begin
                    // A count of zero means one byte, and no more than MAX_READ at once.
                    n = (r.read_count == 0) ? 1 :
                        ((r.read_count > MAX_READ) ? MAX_READ : int'(r.read_count));
                    if (n > int'(pipe_fill[slot]))
                        n = int'(pipe_fill[slot]);
                    for (i = 0; i < n; i++)
                    begin
                        addr = slot * RING_DEPTH + int'(pipe_rd_ptr[slot]);
                        owe_result(ST_OK, ring_copy[addr], i == n - 1, '0, '0, in_use, is_rd);
                        pipe_rd_ptr[slot] = pipe_rd_ptr[slot] + 1'b1;
                        pipe_fill[slot]   = pipe_fill[slot] - 1'b1;
                    end
                end
            end
            MODE_WRITE:
            begin
                if (!in_use || even || !reader_live[slot])
                    owe_result(ST_ERROR, '0, 1'b1, '0, '0, in_use, is_rd);
                else if (pipe_fill[slot] >= RING_DEPTH)
                    owe_result(ST_BLOCK, '0, 1'b1, '0, '0, in_use, is_rd);
                else
                begin
                    ring_copy[slot * RING_DEPTH + int'(pipe_wr_ptr[slot])] = r.write_byte;
                    pipe_wr_ptr[slot] = pipe_wr_ptr[slot] + 1'b1;
                    pipe_fill[slot]   = pipe_fill[slot] + 1'b1;
                    owe_result(ST_OK, '0, 1'b1, '0, '0, in_use, is_rd);
                end
            end
            default:
            begin
                if (!in_use)
                    owe_result(ST_ERROR, '0, 1'b1, '0, '0, in_use, is_rd);
                else
                begin
                    if (even)
                        reader_live[slot] = 1'b0;
                    else
                        writer_live[slot] = 1'b0;
                    if (!reader_live[slot] && !writer_live[slot])
                        slot_busy[slot] = 1'b0;
                    owe_result(ST_OK, '0, 1'b1, '0, '0, in_use, is_rd);
                end
            end
        endcase
    endfunction

    function automatic req_t make_req(input mode_t m, input logic [HANDLE_W-1:0] h,
                                      input logic [BYTE_W-1:0] b, input logic [COUNT_W-1:0] c);
        req_t r;
        r.mode       = m;
        r.handle     = h;
        r.write_byte = b;
        r.read_count = c;
        return r;
    endfunction

    // Read end of a slot, or its write end, under the current base.
    function automatic logic [HANDLE_W-1:0] pipe_handle(input int slot, input bit write_end);
        return HANDLE_W'(base_now) + HANDLE_W'(2 * slot) + HANDLE_W'(write_end);
    endfunction

    // Mostly well-formed requests on handles inside the table, with some noise mixed in.
    function automatic req_t random_req();
        int pick;
        int slot;
        logic [BYTE_W-1:0]  b;
        logic [COUNT_W-1:0] c;

        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, PIPE_COUNT - 1);
        b    = BYTE_W'($urandom);
        c    = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom) : COUNT_W'($urandom_range(1, 6));
        if (pick < 8)
            return make_req(MODE_CREATE, HANDLE_W'($urandom), b, c);
        else if (pick < 50)
            return make_req(MODE_WRITE, pipe_handle(slot, 1'b1), b, c);
        else if (pick < 78)
            return make_req(MODE_READ, pipe_handle(slot, 1'b0), b, c);
        else if (pick < 88)
            return make_req(MODE_CLOSE, pipe_handle(slot, $urandom_range(0, 1)), b, c);
        else if (pick < 94)
            return make_req(mode_t'($urandom_range(0, 3)), HANDLE_W'($urandom), b,
                            COUNT_W'($urandom));
        else
            return make_req(mode_t'($urandom_range(0, 3)),
                            ($urandom_range(0, 1) != 0) ? pipe_handle(-1, 1'b1)
                                                        : pipe_handle(PIPE_COUNT, 1'b0),
                            b, COUNT_W'($urandom));
    endfunction

    // Offers one request, after a random gap while gaps are enabled, and predicts it once it is taken.
    task automatic issue_request(input req_t r);
        int gap;
        gap = idle_en ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_data  <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        predict_pipe_results(r);
    endtask

    // Stops offering requests and waits for every owed result.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_handle_base(input logic [BASE_W-1:0] value);
        wait_for_drain();
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        base_now = value;
    endtask

    // Error paths, create until full, reads and writes at the edges, and every close case.
    task automatic test_directed_cases();
        issue_request(make_req(MODE_READ,  pipe_handle(0, 1'b0), 8'h00, 7'd1));
        issue_request(make_req(MODE_WRITE, pipe_handle(0, 1'b1), 8'h11, 7'd1));
        issue_request(make_req(MODE_CLOSE, pipe_handle(0, 1'b0), 8'h00, 7'd1));
        repeat (PIPE_COUNT + 1)
            issue_request(make_req(MODE_CREATE, '0, 8'h00, 7'd0));
        issue_request(make_req(MODE_READ,  pipe_handle(0, 1'b0), 8'h00, 7'd4));
        issue_request(make_req(MODE_WRITE, pipe_handle(0, 1'b1), 8'h00, 7'd0));
        issue_request(make_req(MODE_WRITE, pipe_handle(0, 1'b1), 8'hFF, 7'd127));
        issue_request(make_req(MODE_WRITE, pipe_handle(0, 1'b0), 8'h5A, 7'd1));
        issue_request(make_req(MODE_READ,  pipe_handle(0, 1'b1), 8'h00, 7'd8));
        issue_request(make_req(MODE_READ,  pipe_handle(0, 1'b0), 8'h00, 7'd0));
        issue_request(make_req(MODE_READ,  pipe_handle(0, 1'b0), 8'h00, 7'd127));
        issue_request(make_req(MODE_WRITE, pipe_handle(0, 1'b1), 8'hA5, 7'd1));
        // Bytes left behind a closed writer still come out, then end of stream.
        issue_request(make_req(MODE_CLOSE, pipe_handle(0, 1'b1), 8'h00, 7'd1));
        issue_request(make_req(MODE_READ,  pipe_handle(0, 1'b0), 8'h00, 7'd64));
        issue_request(make_req(MODE_READ,  pipe_handle(0, 1'b0), 8'h00, 7'd64));
        issue_request(make_req(MODE_CLOSE, pipe_handle(0, 1'b1), 8'h00, 7'd1));
        // A closed reader may still read, but writes are then refused.
        issue_request(make_req(MODE_WRITE, pipe_handle(1, 1'b1), 8'h3C, 7'd1));
        issue_request(make_req(MODE_CLOSE, pipe_handle(1, 1'b0), 8'h00, 7'd1));
        issue_request(make_req(MODE_READ,  pipe_handle(1, 1'b0), 8'h00, 7'd2));
        issue_request(make_req(MODE_WRITE, pipe_handle(1, 1'b1), 8'hC3, 7'd1));
        issue_request(make_req(MODE_CLOSE, pipe_handle(1, 1'b1), 8'h00, 7'd1));
        // Handles outside the table, then a freed slot is handed out again.
        issue_request(make_req(MODE_READ,  pipe_handle(-1, 1'b1), 8'h00, 7'd1));
        issue_request(make_req(MODE_CLOSE, pipe_handle(PIPE_COUNT, 1'b0), 8'h00, 7'd1));
        issue_request(make_req(MODE_CLOSE, pipe_handle(0, 1'b0), 8'h00, 7'd1));
        issue_request(make_req(MODE_CREATE, '1, 8'h00, 7'd0));
    endtask

    // Streams a burst of bytes through one fresh pipe and empties it with long reads.
    task automatic test_full_pipe();
        int fresh;
        int i;

        fresh = -1;
        for (i = 0; i < PIPE_COUNT; i++)
            if (fresh < 0 && !slot_busy[i])
                fresh = i;
        if (fresh < 0)
        begin
            fresh = PIPE_COUNT - 1;
            issue_request(make_req(MODE_CLOSE, pipe_handle(fresh, 1'b0), 8'h00, 7'd1));
            issue_request(make_req(MODE_CLOSE, pipe_handle(fresh, 1'b1), 8'h00, 7'd1));
        end
        issue_request(make_req(MODE_CREATE, '0, 8'h00, 7'd0));
        repeat (100)
            issue_request(make_req(MODE_WRITE, pipe_handle(fresh, 1'b1), BYTE_W'($urandom),
                                   7'd1));
        issue_request(make_req(MODE_READ, pipe_handle(fresh, 1'b0), 8'h00, 7'd64));
        issue_request(make_req(MODE_READ, pipe_handle(fresh, 1'b0), 8'h00, 7'd36));
        repeat (40)
            issue_request(make_req(MODE_WRITE, pipe_handle(fresh, 1'b1), BYTE_W'($urandom),
                                   7'd1));
        while (pipe_fill[fresh] != 0)
            issue_request(make_req(MODE_READ, pipe_handle(fresh, 1'b0), 8'h00, 7'd64));
        issue_request(make_req(MODE_READ, pipe_handle(fresh, 1'b0), 8'h00, 7'd64));
    endtask

    // The result side holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        wait_for_drain();
        idle_en = 1'b0;
        hold_go <= 1'b1;
        repeat (40)
            issue_request(make_req(MODE_WRITE, pipe_handle(0, 1'b1), BYTE_W'($urandom),
                                   7'd1));
        repeat (6)
            issue_request(make_req(MODE_READ, pipe_handle(0, 1'b0), 8'h00, 7'd8));
        wait_for_drain();
        idle_en = 1'b1;
    endtask

    task automatic test_random_traffic(input int count, input logic [BASE_W-1:0] base,
                                       input bit with_idle);
        write_handle_base(base);
        idle_en = with_idle;
        repeat (count)
            issue_request(random_req());
    endtask

    // Result side: random stalls, long hold-off on request, and checking of each result.
    initial
    begin : result_checker
        res_t want;
        int   stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result at cycle %0d: %s", cycle_count,
                                 res_text(res_data));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_data.status !== want.status ||
                        res_data.read_byte !== want.read_byte ||
                        res_data.last !== want.last ||
                        res_data.new_read_handle !== want.new_read_handle ||
                        res_data.new_write_handle !== want.new_write_handle ||
                        res_data.handle_in_use !== want.handle_in_use ||
                        res_data.handle_is_read_end !== want.handle_is_read_end)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("mismatch at cycle %0d: expected %s, got %s", cycle_count,
                                     res_text(want), res_text(res_data));
                    end
                end
                stall_left = idle_en ? $urandom_range(0, 9) : 0;
            end
            if (res_hold)
                res_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // Long hold-off on the result side, counted here once a test asks for it.
    initial
    begin : long_hold
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go  <= 1'b0;
                res_hold <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                res_hold <= 1'b0;
            end
        end
    end

    // Test sequence.
    initial
    begin : test_sequence
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_full_pipe();
        test_backpressure();
        test_random_traffic(50, BASE_W'($urandom_range(1, 2046)), 1'b1);
        test_random_traffic(50, '0, 1'b1);
        test_random_traffic(50, '1, 1'b0);
        test_random_traffic(50, BASE_RESET, 1'b1);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
hdl/mcpf_pkg.sv
hdl/mcpf_ring_ram.sv
hdl/multi_channel_pipe_fifo.sv
hdl/mcpf_checker.sv
dv/multi_channel_pipe_fifo_tb.sv
